// ----- rtl/kls_pkg.sv -----
// ----------------------------------------------------------------------------
// kls_pkg
// Types, codes and timing constants shared by the keyboard line driver.
// ----------------------------------------------------------------------------
package kls_pkg;

   localparam int TIMER_WIDTH = 20;
   localparam int SHORT_W     = 10;
   localparam int LONG_W      = 20;
   localparam int CMP_W       = (TIMER_WIDTH > LONG_W) ? TIMER_WIDTH : LONG_W;
   localparam int ADDR_W      = 5;
   localparam int DATA_W      = 32;

   localparam logic [TIMER_WIDTH-1:0] TMASK = {TIMER_WIDTH{1'b1}};

   // raw codes are shifted left by one (top bit dropped) before they go on the line
   localparam logic [7:0] RAW_RESET  = 8'h78;
   localparam logic [7:0] RAW_INIT   = 8'hFD;
   localparam logic [7:0] RAW_TERM   = 8'hFE;
   localparam logic [7:0] CODE_RESET = {RAW_RESET[6:0], 1'b0};
   localparam logic [7:0] CODE_INIT  = {RAW_INIT[6:0], 1'b0};
   localparam logic [7:0] CODE_TERM  = {RAW_TERM[6:0], 1'b0};
   localparam logic [7:0] MSB_MASK   = 8'h80;
   localparam logic [1:0] LED_MASK   = 2'h3;
   localparam logic [CMP_W-1:0] GAP_TICKS = CMP_W'(200);
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   // power-up sequence steps
   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_INIT = 2'd1;
   localparam logic [1:0] STEP_TERM = 2'd2;
   localparam logic [1:0] STEP_DONE = 2'd3;

   // register indexes (paddr[4:2])
   localparam logic [2:0] REG_SETUP      = 3'd0;
   localparam logic [2:0] REG_CLK_LOW    = 3'd1;
   localparam logic [2:0] REG_CLK_HIGH   = 3'd2;
   localparam logic [2:0] REG_HANDSHAKE  = 3'd3;
   localparam logic [2:0] REG_RESET      = 3'd4;
   localparam logic [2:0] REG_SYNC_PER   = 3'd5;
   localparam logic [2:0] REG_SYNC_WIDTH = 3'd6;
   localparam logic [2:0] REG_STARTUP    = 3'd7;

   typedef enum logic [7:0] {
      PH_STARTUP   = 8'b0000_0001,
      PH_SETUP     = 8'b0000_0010,
      PH_CLK_LOW   = 8'b0000_0100,
      PH_CLK_HIGH  = 8'b0000_1000,
      PH_HANDSHAKE = 8'b0001_0000,
      PH_RESET     = 8'b0010_0000,
      PH_GAP       = 8'b0100_0000,
      PH_IDLE      = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] byte_value;
      logic [1:0] led_pins;
   } req_type;

   typedef struct packed {
      logic       clock_line;
      logic       data_line;
      logic       data_driven;
      logic       reset_line;
      logic       led_report_valid;
      logic [1:0] led_report;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [SHORT_W-1:0] setup_ticks;
      logic [SHORT_W-1:0] clock_low_ticks;
      logic [SHORT_W-1:0] clock_high_ticks;
      logic [LONG_W-1:0]  handshake_ticks;
      logic [LONG_W-1:0]  reset_pulse_ticks;
      logic [LONG_W-1:0]  sync_period_ticks;
      logic [SHORT_W-1:0] sync_width_ticks;
      logic [LONG_W-1:0]  startup_wait_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [3:0] bit_index;
   } status_type;

   function automatic logic [CMP_W-1:0] at_least_one(input logic [CMP_W-1:0] v);
      at_least_one = (v == '0) ? CMP_W'(1) : v;
   endfunction

endpackage

// ----- rtl/kls_csr.sv -----
// ----------------------------------------------------------------------------
// kls_csr
// Timing register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module kls_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [kls_pkg::ADDR_W-1:0]  paddr,
   input  logic [kls_pkg::DATA_W-1:0]  pwdata,
   output logic [kls_pkg::DATA_W-1:0]  prdata,
   output kls_pkg::cfg_type            cfg
);
   import kls_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setup_ticks        <= SHORT_W'(20);
         cfg_ff.clock_low_ticks    <= SHORT_W'(20);
         cfg_ff.clock_high_ticks   <= SHORT_W'(50);
         cfg_ff.handshake_ticks    <= LONG_W'(5000);
         cfg_ff.reset_pulse_ticks  <= LONG_W'(500000);
         cfg_ff.sync_period_ticks  <= LONG_W'(1000000);
         cfg_ff.sync_width_ticks   <= SHORT_W'(64);
         cfg_ff.startup_wait_ticks <= LONG_W'(1000000);
      end else if (wr_en) begin
         case (reg_idx)
            REG_SETUP:      cfg_ff.setup_ticks        <= pwdata[SHORT_W-1:0];
            REG_CLK_LOW:    cfg_ff.clock_low_ticks    <= pwdata[SHORT_W-1:0];
            REG_CLK_HIGH:   cfg_ff.clock_high_ticks   <= pwdata[SHORT_W-1:0];
            REG_HANDSHAKE:  cfg_ff.handshake_ticks    <= pwdata[LONG_W-1:0];
            REG_RESET:      cfg_ff.reset_pulse_ticks  <= pwdata[LONG_W-1:0];
            REG_SYNC_PER:   cfg_ff.sync_period_ticks  <= pwdata[LONG_W-1:0];
            REG_SYNC_WIDTH: cfg_ff.sync_width_ticks   <= pwdata[SHORT_W-1:0];
            REG_STARTUP:    cfg_ff.startup_wait_ticks <= pwdata[LONG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SETUP:      prdata = DATA_W'(cfg_ff.setup_ticks);
         REG_CLK_LOW:    prdata = DATA_W'(cfg_ff.clock_low_ticks);
         REG_CLK_HIGH:   prdata = DATA_W'(cfg_ff.clock_high_ticks);
         REG_HANDSHAKE:  prdata = DATA_W'(cfg_ff.handshake_ticks);
         REG_RESET:      prdata = DATA_W'(cfg_ff.reset_pulse_ticks);
         REG_SYNC_PER:   prdata = DATA_W'(cfg_ff.sync_period_ticks);
         REG_SYNC_WIDTH: prdata = DATA_W'(cfg_ff.sync_width_ticks);
         REG_STARTUP:    prdata = DATA_W'(cfg_ff.startup_wait_ticks);
         default:        prdata = '0;
      endcase
   end

endmodule

// ----- rtl/kls_core.sv -----
// ----------------------------------------------------------------------------
// kls_core
// Per-tick line sequencer: phase timing, sync pulse, bit shifting, LED change.
// ----------------------------------------------------------------------------
module kls_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  kls_pkg::req_type     req,
   input  kls_pkg::cfg_type     cfg,
   output kls_pkg::rsp_type     rsp,
   output kls_pkg::status_type  status
);
   import kls_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [3:0]              bit_index_ff, bit_index_in;
   logic [7:0]              shift_byte_ff, shift_byte_in;
   logic [TIMER_WIDTH-1:0]  phase_timer_ff, phase_timer_in;
   logic [TIMER_WIDTH-1:0]  sync_timer_ff, sync_timer_in;
   logic [SHORT_W-1:0]      sync_rem_ff, sync_rem_in;
   logic [1:0]              last_leds_ff, last_leds_in;
   logic [1:0]              step_ff, step_in;

   logic [CMP_W-1:0]        phase_len;
   logic [TIMER_WIDTH-1:0]  sync_inc;
   logic [1:0]              leds;

   assign status.phase     = phase_ff;
   assign status.bit_index = bit_index_ff;
   assign leds             = req.led_pins & LED_MASK;

   always_comb begin
      case (phase_ff)
         PH_STARTUP:   phase_len = CMP_W'(cfg.startup_wait_ticks);
         PH_SETUP:     phase_len = at_least_one(CMP_W'(cfg.setup_ticks));
         PH_CLK_LOW:   phase_len = at_least_one(CMP_W'(cfg.clock_low_ticks));
         PH_CLK_HIGH:  phase_len = at_least_one(CMP_W'(cfg.clock_high_ticks));
         PH_HANDSHAKE: phase_len = at_least_one(CMP_W'(cfg.handshake_ticks));
         PH_RESET:     phase_len = at_least_one(CMP_W'(cfg.reset_pulse_ticks));
         PH_GAP:       phase_len = GAP_TICKS;
         default:      phase_len = CMP_W'(1);
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      bit_index_in   = bit_index_ff;
      shift_byte_in  = shift_byte_ff;
      phase_timer_in = phase_timer_ff;
      step_in        = step_ff;
      last_leds_in   = last_leds_ff;
      rsp            = '0;
      rsp.clock_line  = 1'b1;
      rsp.data_line   = 1'b1;
      rsp.data_driven = 1'b1;
      rsp.reset_line  = 1'b1;

      // advance the sync period
      sync_inc      = (sync_timer_ff != TMASK) ? sync_timer_ff + 1'b1 : sync_timer_ff;
      sync_timer_in = sync_inc;
      sync_rem_in   = sync_rem_ff;
      if (CMP_W'(sync_inc) >= at_least_one(CMP_W'(cfg.sync_period_ticks)) ||
          sync_inc == TMASK) begin
         sync_timer_in = '0;
         sync_rem_in   = (cfg.sync_width_ticks == '0) ? SHORT_W'(1) : cfg.sync_width_ticks;
      end

      // close the current phase
      if (phase_ff != PH_IDLE &&
          (CMP_W'(phase_timer_ff) >= phase_len || phase_timer_ff == TMASK)) begin
         phase_timer_in = '0;
         case (phase_ff)
            PH_STARTUP: begin
               step_in       = STEP_INIT;
               shift_byte_in = CODE_INIT;
               bit_index_in  = '0;
               phase_in      = PH_SETUP;
            end
            PH_SETUP:    phase_in = PH_CLK_LOW;
            PH_CLK_LOW:  phase_in = PH_CLK_HIGH;
            PH_CLK_HIGH: begin
               bit_index_in = bit_index_ff + 1'b1;
               phase_in     = (bit_index_in >= BITS_PER_BYTE) ? PH_HANDSHAKE : PH_SETUP;
            end
            PH_HANDSHAKE: begin
               if (step_ff == STEP_INIT) begin
                  phase_in = PH_GAP;
               end else begin
                  if (step_ff == STEP_TERM) begin
                     step_in = STEP_DONE;
                  end
                  phase_in = PH_IDLE;
               end
            end
            PH_GAP: begin
               step_in       = STEP_TERM;
               shift_byte_in = CODE_TERM;
               bit_index_in  = '0;
               phase_in      = PH_SETUP;
            end
            default: phase_in = PH_IDLE;
         endcase
      end

      // take a new byte only while idle
      if (phase_in == PH_IDLE && req.byte_valid && req.byte_value != '0) begin
         phase_timer_in = '0;
         if (req.byte_value == CODE_RESET) begin
            phase_in = PH_RESET;
         end else begin
            shift_byte_in = req.byte_value;
            bit_index_in  = '0;
            phase_in      = PH_SETUP;
         end
      end

      // drive the lines; MSB first, inverted on the wire
      if (phase_in inside {PH_SETUP, PH_CLK_LOW, PH_CLK_HIGH}) begin
         rsp.data_line  = ((shift_byte_in << bit_index_in[2:0]) & MSB_MASK) == '0;
         rsp.clock_line = (phase_in != PH_CLK_LOW);
      end else if (phase_in == PH_HANDSHAKE) begin
         rsp.data_driven = 1'b0;
      end else if (phase_in == PH_RESET) begin
         rsp.reset_line = 1'b0;
      end

      if (sync_rem_in != '0) begin
         if (rsp.data_driven) begin
            rsp.data_line = 1'b0;
         end
         sync_rem_in = sync_rem_in - 1'b1;
      end

      if (leds != last_leds_ff) begin
         rsp.led_report_valid = 1'b1;
         rsp.led_report       = leds;
         last_leds_in         = leds;
      end

      rsp.busy_res = (phase_in != PH_IDLE);

      if (phase_in != PH_IDLE && phase_timer_in != TMASK) begin
         phase_timer_in = phase_timer_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STARTUP;
         bit_index_ff   <= '0;
         shift_byte_ff  <= '0;
         phase_timer_ff <= '0;
         sync_timer_ff  <= '0;
         sync_rem_ff    <= '0;
         last_leds_ff   <= '0;
         step_ff        <= STEP_NONE;
      end else if (accept) begin
         phase_ff       <= phase_in;
         bit_index_ff   <= bit_index_in;
         shift_byte_ff  <= shift_byte_in;
         phase_timer_ff <= phase_timer_in;
         sync_timer_ff  <= sync_timer_in;
         sync_rem_ff    <= sync_rem_in;
         last_leds_ff   <= last_leds_in;
         step_ff        <= step_in;
      end
   end

endmodule

// ----- rtl/kls_outq.sv -----
// ----------------------------------------------------------------------------
// kls_outq
// Result register with a skid stage, so one stalled result does not stop ticks.
// ----------------------------------------------------------------------------
module kls_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  kls_pkg::rsp_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output kls_pkg::rsp_type  out_data
);
   import kls_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    push;
   logic    pop;

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign push      = in_valid & ~skid_valid_ff;
   assign pop       = out_valid_ff & out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff | push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_ff <= skid_valid_ff ? skid_ff : in_data;
      end
      if (push && out_valid_ff && !pop) begin
         skid_ff <= in_data;
      end
   end

endmodule

// ----- rtl/keyboard_line_serial_driver.sv -----
// ----------------------------------------------------------------------------
// keyboard_line_serial_driver
// Drives a synchronous keyboard clock/data line and a reset line, one tick
// per request.
// ----------------------------------------------------------------------------
//   channel   ports                        direction  payload
//   request   req_valid/req_ready/req_data  in        byte_valid, byte_value, led_pins
//   response  rsp_valid/rsp_ready/rsp_data  out       line levels, LED report, busy
//   config    psel/penable/pwrite/paddr/... in        eight timing registers
//
// Each request is one tick; a request can be taken every cycle while req_ready
// is high. The response is registered in the result register.
// A two-deep result stage (register plus skid) keeps taking requests while a
// response is stalled; req_ready drops only when both stages hold a response.
// Reset is synchronous and active high; it restores the register defaults and
// starts the power-up wait.
// ----------------------------------------------------------------------------
module keyboard_line_serial_driver (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  kls_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output kls_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [kls_pkg::ADDR_W-1:0]  paddr,
   input  logic [kls_pkg::DATA_W-1:0]  pwdata,
   output logic [kls_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import kls_pkg::*;

   cfg_type    cfg;
   rsp_type    core_rsp;
   status_type status;
   logic       accept;

   // writes always complete in the access cycle
   assign pready = 1'b1;

   // a request is a tick: advance the sequencer only when it is taken
   assign accept = req_valid & req_ready;

   kls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   // all per-tick logic sits between the request and the result register
   kls_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .cfg    (cfg),
      .rsp    (core_rsp),
      .status (status)
   );

   // hold results here while the response side stalls
   kls_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // the bit counter never runs past one full byte
   assert property (@(posedge clock) disable iff (reset)
      status.bit_index <= BITS_PER_BYTE)
      else $error("bit index beyond byte length");

   // the sequencer sits in exactly one phase
   assert property (@(posedge clock) disable iff (reset)
      $onehot(status.phase))
      else $error("phase register not one-hot");

   // requests are refused only when a response is waiting
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

   // an idle response leaves the clock and reset lines high and the data line driven
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |->
         rsp_data.clock_line && rsp_data.reset_line && rsp_data.data_driven)
      else $error("line active while idle");

   // a released data line reads high
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.data_driven |-> rsp_data.data_line && rsp_data.busy_res)
      else $error("released data line not high");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyboard line serial driver. Every request is
// one tick; a local line model predicts the line levels, LED report and busy
// flag for each tick, and a checker compares each response against them.
// ----------------------------------------------------------------------------
module tb;
   import kls_pkg::*;

   localparam int IDLE_LIMIT    = 5000;   // cycles with no handshake on either side
   localparam int SETTLE_CYCLES = 10;     // extra wait after the queue drains; leave generous margin
   localparam int MAX_REPORTS   = 10;
   localparam int RANDOM_ITEMS  = 300;    // per idling mode, three modes
   localparam int RETIME_EVERY  = 150;    // random requests between timing changes

   typedef logic [TIMER_WIDTH-1:0] tick_type;

   // -------------------------------------------------------------------------
   // DUT ports, all driven to known values from time zero
   // -------------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              psel      = 1'b0;
   logic              penable   = 1'b0;
   logic              pwrite    = 1'b0;
   logic [ADDR_W-1:0] paddr     = '0;
   logic [DATA_W-1:0] pwdata    = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   keyboard_line_serial_driver i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Line model: our own copy of the timing registers and the driver state.
   // Advanced once per accepted request, in the same order as the DUT.
   // -------------------------------------------------------------------------
   tick_type   line_cfg [8];
   phase_type  ln_phase;
   logic [3:0] ln_bit;
   logic [7:0] ln_shift;
   tick_type   ln_timer;
   tick_type   sync_count;
   logic [9:0] sync_left;
   logic [1:0] led_seen;
   logic [1:0] power_step;

   // expected line samples, oldest first
   rsp_type    line_levels_due [$];

   // stimulus knobs and bookkeeping
   int         send_idle_pct = 21;
   int         recv_idle_pct = 76;
   logic [1:0] cur_leds      = 2'b00;
   int         mismatches    = 0;
   int         ticks_sent    = 0;
   int         samples_checked = 0;
   int         bytes_shifted = 0;
   int         reset_pulses  = 0;
   int         led_reports   = 0;
   int         reg_writes    = 0;

   function automatic logic [31:0] reg_mask(input logic [2:0] idx);
      case (idx)
         REG_SETUP, REG_CLK_LOW, REG_CLK_HIGH, REG_SYNC_WIDTH: return 32'h0000_03FF;
         default:                                              return 32'h000F_FFFF;
      endcase
   endfunction

   // zero-length registers behave as one tick
   function automatic tick_type min_one(input tick_type v);
      return (v == '0) ? tick_type'(1) : v;
   endfunction

   function automatic tick_type phase_span(input phase_type ph);
      case (ph)
         PH_STARTUP:   return line_cfg[REG_STARTUP];
         PH_SETUP:     return min_one(line_cfg[REG_SETUP]);
         PH_CLK_LOW:   return min_one(line_cfg[REG_CLK_LOW]);
         PH_CLK_HIGH:  return min_one(line_cfg[REG_CLK_HIGH]);
         PH_HANDSHAKE: return min_one(line_cfg[REG_HANDSHAKE]);
         PH_RESET:     return min_one(line_cfg[REG_RESET]);
         PH_GAP:       return tick_type'(GAP_TICKS);
         default:      return tick_type'(1);
      endcase
   endfunction

   function automatic void power_on_state();
      line_cfg[REG_SETUP]      = tick_type'(20);
      line_cfg[REG_CLK_LOW]    = tick_type'(20);
      line_cfg[REG_CLK_HIGH]   = tick_type'(50);
      line_cfg[REG_HANDSHAKE]  = tick_type'(5000);
      line_cfg[REG_RESET]      = tick_type'(500000);
      line_cfg[REG_SYNC_PER]   = tick_type'(1000000);
      line_cfg[REG_SYNC_WIDTH] = tick_type'(64);
      line_cfg[REG_STARTUP]    = tick_type'(1000000);
      ln_phase   = PH_STARTUP;
      ln_bit     = '0;
      ln_shift   = '0;
      ln_timer   = '0;
      sync_count = '0;
      sync_left  = '0;
      led_seen   = '0;
      power_step = STEP_NONE;
   endfunction

   function automatic void load_byte(input logic [7:0] b);
      ln_shift = b;
      ln_bit   = '0;
      ln_phase = PH_SETUP;
      ln_timer = '0;
   endfunction

   function automatic void advance_phase();
      ln_timer = '0;
      case (ln_phase)
         PH_STARTUP: begin
            power_step = STEP_INIT;
            load_byte(CODE_INIT);
         end
         PH_SETUP:    ln_phase = PH_CLK_LOW;
         PH_CLK_LOW:  ln_phase = PH_CLK_HIGH;
         PH_CLK_HIGH: begin
            ln_bit   = ln_bit + 4'd1;
            ln_phase = (ln_bit >= BITS_PER_BYTE) ? PH_HANDSHAKE : PH_SETUP;
         end
         PH_HANDSHAKE: begin
            // first power-up code waits out the gap; anything else goes idle
            if (power_step == STEP_INIT) begin
               ln_phase = PH_GAP;
            end else begin
               if (power_step == STEP_TERM) power_step = STEP_DONE;
               ln_phase = PH_IDLE;
            end
         end
         PH_GAP: begin
            power_step = STEP_TERM;
            load_byte(CODE_TERM);
         end
         default: ln_phase = PH_IDLE;
      endcase
   endfunction

   // One tick of the driver: returns the line sample the DUT must respond with.
   function automatic rsp_type line_tick(input req_type rq);
      rsp_type r;
      r             = '0;
      r.clock_line  = 1'b1;
      r.data_line   = 1'b1;
      r.data_driven = 1'b1;
      r.reset_line  = 1'b1;

      // periodic sync, saturating counter
      if (sync_count < TMASK) sync_count = sync_count + 1'b1;
      if (sync_count >= min_one(line_cfg[REG_SYNC_PER]) || sync_count >= TMASK) begin
         sync_count = '0;
         sync_left  = 10'(min_one(line_cfg[REG_SYNC_WIDTH]));
      end

      // close the current phase before looking at the new byte
      if (ln_phase != PH_IDLE && (ln_timer >= phase_span(ln_phase) || ln_timer >= TMASK))
         advance_phase();

      // bytes are taken only while idle; zero is never a code
      if (ln_phase == PH_IDLE && rq.byte_valid && rq.byte_value != 8'h00) begin
         if (rq.byte_value == CODE_RESET) begin
            ln_phase = PH_RESET;
            ln_timer = '0;
            reset_pulses++;
         end else begin
            load_byte(rq.byte_value);
            bytes_shifted++;
         end
      end

      case (ln_phase)
         PH_SETUP, PH_CLK_LOW, PH_CLK_HIGH: begin
            // MSB first, inverted on the wire
            r.data_line = ~ln_shift[3'd7 - ln_bit[2:0]];
            if (ln_phase == PH_CLK_LOW) r.clock_line = 1'b0;
         end
         PH_HANDSHAKE: r.data_driven = 1'b0;
         PH_RESET:     r.reset_line  = 1'b0;
         default: ;
      endcase

      // sync pulls a driven data line low; a released line reads high
      if (sync_left != '0) begin
         if (r.data_driven) r.data_line = 1'b0;
         sync_left = sync_left - 10'd1;
      end

      if ((rq.led_pins & LED_MASK) != led_seen) begin
         r.led_report_valid = 1'b1;
         r.led_report       = rq.led_pins & LED_MASK;
         led_seen           = rq.led_pins & LED_MASK;
         led_reports++;
      end

      r.busy_res = (ln_phase != PH_IDLE);
      if (ln_phase != PH_IDLE && ln_timer < TMASK) ln_timer = ln_timer + 1'b1;
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // -------------------------------------------------------------------------
   // Response side: random backpressure and the checker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response with the oldest predicted sample.
   always @(posedge clock) begin : check_line
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         samples_checked++;
         if (line_levels_due.size() == 0) begin
            note_failure("response with no request outstanding");
         end else begin
            want = line_levels_due.pop_front();
            if (rsp_data.clock_line       !== want.clock_line  ||
                rsp_data.data_line        !== want.data_line   ||
                rsp_data.data_driven      !== want.data_driven ||
                rsp_data.reset_line       !== want.reset_line  ||
                rsp_data.led_report_valid !== want.led_report_valid ||
                rsp_data.led_report       !== want.led_report  ||
                rsp_data.busy_res         !== want.busy_res)
               note_failure({
                  $sformatf("sample %0d exp clk=%b dat=%b drv=%b rst=%b rv=%b rep=%0d busy=%b",
                     samples_checked,
                     want.clock_line, want.data_line, want.data_driven, want.reset_line,
                     want.led_report_valid, want.led_report, want.busy_res),
                  $sformatf(", got clk=%b dat=%b drv=%b rst=%b rv=%b rep=%0d busy=%b",
                     rsp_data.clock_line, rsp_data.data_line, rsp_data.data_driven,
                     rsp_data.reset_line, rsp_data.led_report_valid, rsp_data.led_report,
                     rsp_data.busy_res)});
         end
      end
   end

   // Drop the run if neither channel moves for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no handshake for %0d cycles, %0d samples outstanding",
               IDLE_LIMIT, line_levels_due.size());
      $display("FAIL");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Send one tick. Idle the valid at random first, then hold the request
   // until it is accepted and predict its sample at that edge.
   task automatic send_tick(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      line_levels_due.push_back(line_tick(item));
      ticks_sent++;
   endtask

   task automatic tick(input logic v, input logic [7:0] b);
      req_type item;
      item.byte_valid = v;
      item.byte_value = b;
      item.led_pins   = cur_leds;
      send_tick(item);
   endtask

   // Filler ticks: random bytes (dropped while busy) and the odd LED change.
   task automatic run_ticks(input int n);
      repeat (n) begin
         if ($urandom_range(7) == 0) cur_leds = 2'($urandom_range(3));
         tick(1'($urandom_range(1)), 8'($urandom_range(255)));
      end
   endtask

   task automatic run_until_idle();
      while (ln_phase != PH_IDLE) run_ticks(1);
   endtask

   // Drop valid and hold off until every predicted sample has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (line_levels_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register port: setup cycle, then access cycle; pready is always high
   // -------------------------------------------------------------------------
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] word;
      mask = reg_mask(idx);
      // junk in the unused upper bits must be ignored
      word = ($urandom() & ~mask) | (value & mask);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({idx, 2'b00});
      pwdata  <= word;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      line_cfg[idx] = tick_type'(word & mask);
      reg_writes++;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [2:0] idx);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== DATA_W'(line_cfg[idx]))
         note_failure($sformatf("register %0d read %h, expected %h",
                                idx, prdata, DATA_W'(line_cfg[idx])));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // Short random timings, zero lengths included, so bytes finish quickly.
   task automatic shuffle_timing();
      csr_write(REG_SETUP,      32'($urandom_range(3)));
      csr_write(REG_CLK_LOW,    32'($urandom_range(3)));
      csr_write(REG_CLK_HIGH,   32'($urandom_range(3)));
      csr_write(REG_HANDSHAKE,  32'($urandom_range(10)));
      csr_write(REG_RESET,      32'($urandom_range(10)));
      csr_write(REG_SYNC_PER,   ($urandom_range(3) == 0) ? 32'($urandom_range(5000, 1000))
                                                         : 32'($urandom_range(120)));
      csr_write(REG_SYNC_WIDTH, 32'($urandom_range(12)));
      csr_write(REG_STARTUP,    $urandom());
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Program fast timings before the first tick (zero startup wait, zero
   // setup and handshake lengths) and read every register back.
   task automatic test_register_access();
      csr_write(REG_SETUP,      32'd0);
      csr_write(REG_CLK_LOW,    32'd1);
      csr_write(REG_CLK_HIGH,   32'd2);
      csr_write(REG_HANDSHAKE,  32'd0);
      csr_write(REG_RESET,      32'd3);
      csr_write(REG_SYNC_PER,   32'd40);
      csr_write(REG_SYNC_WIDTH, 32'd4);
      csr_write(REG_STARTUP,    32'd0);
      for (int i = 0; i < 8; i++) csr_read_check(3'(i));
   endtask

   // Both power-up codes with the fixed gap; bytes arriving meanwhile drop.
   task automatic test_power_up();
      while (!(power_step == STEP_DONE && ln_phase == PH_IDLE)) run_ticks(1);
   endtask

   // Edge byte patterns, the reset code, ignored bytes, every LED value,
   // and a sync that never lets go of the data line.
   task automatic test_code_bytes();
      logic [7:0] codes [10];
      codes = '{8'h01, 8'h80, 8'hFF, 8'hAA, 8'h55, CODE_RESET, CODE_INIT,
                CODE_TERM, 8'h7F, 8'hFE};
      cur_leds = 2'b11;
      tick(1'b1, 8'h00);      // zero byte: ignored even though valid
      cur_leds = 2'b11;
      tick(1'b0, 8'hA5);      // byte without valid: ignored
      foreach (codes[i]) begin
         cur_leds = 2'(i);
         tick(1'b1, codes[i]);
         run_until_idle();
      end
      // zero sync period and width: pulse every tick
      wait_for_results();
      csr_write(REG_SYNC_PER,   32'd0);
      csr_write(REG_SYNC_WIDTH, 32'd0);
      tick(1'b1, 8'h3C);
      run_until_idle();
      wait_for_results();
      csr_write(REG_SYNC_PER,   32'd30);
      csr_write(REG_SYNC_WIDTH, 32'd5);
      tick(1'b1, 8'hC5);
      run_until_idle();
   endtask

   // Start phases with maximum lengths, then shorten them below the elapsed
   // count so each phase closes on the next tick.
   task automatic test_mid_phase_config();
      wait_for_results();
      csr_write(REG_HANDSHAKE, 32'h000F_FFFF);
      csr_write(REG_SETUP,     32'h0000_03FF);
      csr_write(REG_CLK_LOW,   32'h0000_03FF);
      csr_write(REG_CLK_HIGH,  32'h0000_03FF);
      tick(1'b1, 8'hC3);
      run_ticks(12);
      wait_for_results();
      csr_write(REG_SETUP, 32'd2);
      run_ticks(12);
      wait_for_results();
      csr_write(REG_CLK_LOW, 32'd1);
      run_ticks(12);
      wait_for_results();
      csr_write(REG_CLK_HIGH, 32'd2);
      while (ln_phase != PH_HANDSHAKE) run_ticks(1);
      run_ticks(12);
      wait_for_results();
      csr_write(REG_HANDSHAKE, 32'd3);
      run_until_idle();

      // same for the reset pulse
      wait_for_results();
      csr_write(REG_RESET, 32'h000F_FFFF);
      tick(1'b1, CODE_RESET);
      run_ticks(12);
      wait_for_results();
      csr_write(REG_RESET, 32'd2);
      run_until_idle();

      // remaining extremes: no sync within reach, long startup (already past)
      wait_for_results();
      csr_write(REG_SYNC_PER,   32'h000F_FFFF);
      csr_write(REG_SYNC_WIDTH, 32'h0000_03FF);
      csr_write(REG_STARTUP,    32'h000F_FFFF);
      run_ticks(20);
   endtask

   // Mostly well-formed traffic: offer a byte whenever the line is free,
   // random noise while it is busy, timings reshuffled between stretches.
   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int n_items);
      req_type item;
      int      pick;
      wait_for_results();
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      for (int i = 0; i < n_items; i++) begin
         if (i % RETIME_EVERY == 0) begin
            wait_for_results();
            shuffle_timing();
         end
         if ($urandom_range(9) == 0) cur_leds = 2'($urandom_range(3));
         item.led_pins = cur_leds;
         pick = $urandom_range(15);
         if (ln_phase == PH_IDLE && pick < 12) begin
            item.byte_valid = 1'b1;
            if (pick == 0)      item.byte_value = CODE_RESET;
            else if (pick == 1) item.byte_value = 8'h00;
            else                item.byte_value = 8'($urandom_range(255));
         end else begin
            item.byte_valid = ($urandom_range(3) == 0);
            item.byte_value = 8'($urandom_range(255));
         end
         send_tick(item);
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      power_on_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_power_up();
      test_code_bytes();
      test_mid_phase_config();
      test_random_traffic(21, 76, RANDOM_ITEMS);
      test_random_traffic(76, 21, RANDOM_ITEMS);
      test_random_traffic(0, 0, RANDOM_ITEMS);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (line_levels_due.size() != 0)
         note_failure($sformatf("%0d samples never arrived", line_levels_due.size()));

      $display("Covered power-up, %0d shifted bytes, %0d reset pulses, %0d LED reports",
               bytes_shifted, reset_pulses, led_reports);
      $display("%0d ticks sent, %0d samples checked, %0d register writes, %0d mismatches",
               ticks_sent, samples_checked, reg_writes, mismatches);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
